/* hdl/hrrn_pkg.sv */
package hrrn_pkg;

  // item kinds carried on in_tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // field widths of the stream payloads
  localparam int SLOT_W  = 4;
  localparam int VAL_W   = 16;
  localparam int CFG_W   = 5;

  // input tdata layout: slot, run_length, arrival_time, zero padding
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_LEN_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_ARR_LSB  = IN_LEN_LSB + VAL_W;
  localparam int IN_TDATA_W  = 40;

  // output tdata layout: running_slot, idle, job_finished, all_done, tick_count
  localparam int OUT_SLOT_LSB = 0;
  localparam int OUT_IDLE_BIT = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_FIN_BIT  = OUT_IDLE_BIT + 1;
  localparam int OUT_ALL_BIT  = OUT_FIN_BIT + 1;
  localparam int OUT_TICK_LSB = OUT_ALL_BIT + 1;
  localparam int OUT_TDATA_W  = 24;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SERVE = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  // controls from the sequencer to the job table
  typedef struct packed {
    logic load;    // write one slot from a load item
    logic tick;    // apply the end-of-tick update
    logic served;  // a job was served this tick
    logic finish;  // the served job completed this tick
  } tbl_ctl_t;

endpackage

/* hdl/hrrn_ratio_cmp.sv */
module hrrn_ratio_cmp #(
  parameter int TIME_BITS = 16
) (
  input  logic [TIME_BITS-1:0] cand_wait,
  input  logic [TIME_BITS-1:0] cand_len,
  input  logic [TIME_BITS-1:0] best_wait,
  input  logic [TIME_BITS-1:0] best_len,
  output logic                 better
);

  logic [2*TIME_BITS-1:0] lhs;
  logic [2*TIME_BITS-1:0] rhs;

  // cross products stand in for the two response ratios
  assign lhs = (2*TIME_BITS)'(cand_wait) * (2*TIME_BITS)'(best_len);
  assign rhs = (2*TIME_BITS)'(best_wait) * (2*TIME_BITS)'(cand_len);

  // higher ratio wins, then shorter length; equal keeps the lower slot
  assign better = (lhs > rhs) || ((lhs == rhs) && (cand_len < best_len));

endmodule

/* hdl/hrrn_job_table.sv */
module hrrn_job_table #(
  parameter int MAX_JOBS  = 16,
  parameter int TIME_BITS = 16,
  parameter int SW        = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hrrn_pkg::tbl_ctl_t          ctl,
  input  logic [SW-1:0]               wr_idx,
  input  logic [TIME_BITS-1:0]        wr_len,
  input  logic [TIME_BITS-1:0]        wr_arr,
  input  logic [SW-1:0]               srv_idx,
  input  logic [SW-1:0]               rd_idx,
  output logic signed [TIME_BITS:0]   rd_wait,
  output logic [TIME_BITS-1:0]        rd_len,
  output logic                        rd_done
);

  localparam logic signed [TIME_BITS:0] WAIT_MAX = {1'b0, {TIME_BITS{1'b1}}};

  logic signed [TIME_BITS:0] wait_r   [MAX_JOBS];
  logic signed [TIME_BITS:0] wait_nxt [MAX_JOBS];
  logic [TIME_BITS-1:0]      len_r    [MAX_JOBS];
  logic [TIME_BITS-1:0]      len_nxt  [MAX_JOBS];
  logic [MAX_JOBS-1:0]       done_r;
  logic [MAX_JOBS-1:0]       done_nxt;

  // per slot: load writes one slot; a tick ages all but the served one, flags finish
  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      wait_nxt[i] = wait_r[i];
      len_nxt[i]  = len_r[i];
      done_nxt[i] = done_r[i];
      if (ctl.load && (wr_idx == SW'(i))) begin
        len_nxt[i]  = wr_len;
        wait_nxt[i] = -$signed({1'b0, wr_arr});
        done_nxt[i] = (wr_len == '0);
      end else if (ctl.tick) begin
        if (ctl.finish && (srv_idx == SW'(i))) begin
          done_nxt[i] = 1'b1;
        end
        if (!(ctl.served && (srv_idx == SW'(i))) && (wait_r[i] < WAIT_MAX)) begin
          wait_nxt[i] = wait_r[i] + 2'sb01;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        wait_r[i] <= '0;
        len_r[i]  <= '0;
      end
      done_r <= '1;
    end else begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        wait_r[i] <= wait_nxt[i];
        len_r[i]  <= len_nxt[i];
      end
      done_r <= done_nxt;
    end
  end

  // scan read port
  assign rd_wait = wait_r[rd_idx];
  assign rd_len  = len_r[rd_idx];
  assign rd_done = done_r[rd_idx];

endmodule

/* hdl/hrrn_job_scheduler_core.sv */
// hrrn_job_scheduler_core: non-preemptive highest-response-ratio-next scheduler
//
// in_* stream carries items; in_tuser selects the kind (0 load, 1 tick).
//   a load item writes an in-range slot; in_tready stays high after it.
//   a tick item advances time by one and yields one result item on out_*.
// cfg_wr_en/cfg_wr_data set the number of slots in use; write only when idle.
//
// a tick scans every slot through one cross-multiply comparator, one slot
// per cycle, then serves the chosen job and ages the waiting ones, and
// then moves the result to the output register once that register is
// free. in_tready is low while a tick is in progress, so the next item
// waits for the tick to finish.
//
// the output register holds a result until out_tready; a load can still be
// taken meanwhile, and a following tick's result waits for it to drain.
// reset (rst_n low, synchronous) clears all slots to finished, time to zero,
// the slot count to one, and drops out_tvalid.
module hrrn_job_scheduler_core #(
  parameter int MAX_JOBS  = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // slot [3:0], run_length [19:4], arrival_time [35:20], zero [39:36]
  input  logic [hrrn_pkg::IN_TDATA_W-1:0]      in_tdata,
  // kind [0]
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // running_slot [3:0], idle [4], job_finished [5], all_done [6],
  // tick_count [22:7], zero [23]
  output logic [hrrn_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wr_en,
  input  logic [hrrn_pkg::CFG_W-1:0]           cfg_wr_data
);

  localparam int SW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  hrrn_pkg::state_t state_r, state_nxt;

  logic [hrrn_pkg::CFG_W-1:0] job_count_r;
  logic [SW-1:0]              idx_r, idx_nxt;
  logic                       found_r, found_nxt;
  logic [SW-1:0]              best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0]       best_wait_r, best_wait_nxt;
  logic [TIME_BITS-1:0]       best_len_r, best_len_nxt;
  logic [CW-1:0]              nd_r, nd_nxt;
  logic                       busy_r, busy_nxt;
  logic [SW-1:0]              cur_r, cur_nxt;
  logic [TIME_BITS-1:0]       rem_r, rem_nxt;
  logic [TIME_BITS-1:0]       time_r, time_nxt;
  logic [hrrn_pkg::OUT_TDATA_W-1:0] res_r, res_nxt;
  logic [hrrn_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;

  // input field unpacking
  logic [hrrn_pkg::SLOT_W-1:0] in_slot;
  logic [hrrn_pkg::VAL_W-1:0]  in_run_length;
  logic [hrrn_pkg::VAL_W-1:0]  in_arrival_time;
  logic [SW+3:0]               slot_ext;
  logic [TIME_BITS+15:0]       len_ext;
  logic [TIME_BITS+15:0]       arr_ext;
  logic                        slot_ok;
  logic                        in_acc;

  assign in_slot         = in_tdata[hrrn_pkg::IN_SLOT_LSB +: hrrn_pkg::SLOT_W];
  assign in_run_length   = in_tdata[hrrn_pkg::IN_LEN_LSB +: hrrn_pkg::VAL_W];
  assign in_arrival_time = in_tdata[hrrn_pkg::IN_ARR_LSB +: hrrn_pkg::VAL_W];
  assign slot_ext        = (SW+4)'(in_slot);
  assign len_ext         = (TIME_BITS+16)'(in_run_length);
  assign arr_ext         = (TIME_BITS+16)'(in_arrival_time);
  assign slot_ok         = (32'(in_slot) < MAX_JOBS);
  assign in_acc          = in_tvalid && in_tready;

  // job table and comparator
  hrrn_pkg::tbl_ctl_t        tbl_ctl;
  logic [SW-1:0]             srv_idx;
  logic signed [TIME_BITS:0] rd_wait;
  logic [TIME_BITS-1:0]      rd_len;
  logic                      rd_done;
  logic                      cmp_better;

  hrrn_job_table #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS),
    .SW        (SW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .wr_idx  (slot_ext[SW-1:0]),
    .wr_len  (len_ext[TIME_BITS-1:0]),
    .wr_arr  (arr_ext[TIME_BITS-1:0]),
    .srv_idx (srv_idx),
    .rd_idx  (idx_r),
    .rd_wait (rd_wait),
    .rd_len  (rd_len),
    .rd_done (rd_done)
  );

  hrrn_ratio_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .cand_wait (rd_wait[TIME_BITS-1:0]),
    .cand_len  (rd_len),
    .best_wait (best_wait_r),
    .best_len  (best_len_r),
    .better    (cmp_better)
  );

  // scan-side qualifiers
  logic in_use;
  logic eligible;
  assign in_use   = (32'(idx_r) < 32'(job_count_r));
  assign eligible = in_use && !rd_done && (rd_len != '0) && !rd_wait[TIME_BITS];

  // serve-side values
  logic                  start;
  logic                  served;
  logic [TIME_BITS-1:0]  rem_start;
  logic [TIME_BITS-1:0]  rem_dec;
  logic                  finish;
  logic                  cur_in_use;
  logic [CW-1:0]         nd_after;
  logic [TIME_BITS-1:0]  time_inc;
  logic [TIME_BITS+15:0] time_ext;
  logic [SW+3:0]         cur_ext;

  assign start      = !busy_r && found_r;
  assign served     = busy_r || found_r;
  assign srv_idx    = busy_r ? cur_r : best_idx_r;
  assign rem_start  = busy_r ? rem_r : best_len_r;
  assign rem_dec    = (rem_start != '0) ? rem_start - 1'b1 : rem_start;
  assign finish     = served && (rem_dec == '0);
  assign cur_in_use = (32'(srv_idx) < 32'(job_count_r));
  assign nd_after   = nd_r - CW'(finish && cur_in_use);
  assign time_inc   = (time_r != TIME_MAX) ? time_r + 1'b1 : time_r;
  assign time_ext   = (TIME_BITS+16)'(time_inc);
  assign cur_ext    = (SW+4)'(srv_idx);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_wait_nxt  = best_wait_r;
    best_len_nxt   = best_len_r;
    nd_nxt         = nd_r;
    busy_nxt       = busy_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    time_nxt       = time_r;
    res_nxt        = res_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    tbl_ctl        = '0;
    case (state_r)
      hrrn_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == hrrn_pkg::KIND_LOAD) begin
            if (slot_ok) begin
              tbl_ctl.load = 1'b1;
              if (busy_r && (cur_r == slot_ext[SW-1:0])) begin
                busy_nxt = 1'b0;
              end
            end
          end else begin
            idx_nxt   = '0;
            found_nxt = 1'b0;
            nd_nxt    = '0;
            state_nxt = hrrn_pkg::ST_SCAN;
          end
        end
      end
      hrrn_pkg::ST_SCAN: begin
        // one slot per cycle through the shared comparator
        if (!busy_r && eligible && (!found_r || cmp_better)) begin
          found_nxt     = 1'b1;
          best_idx_nxt  = idx_r;
          best_wait_nxt = rd_wait[TIME_BITS-1:0];
          best_len_nxt  = rd_len;
        end
        if (in_use && !rd_done) begin
          nd_nxt = nd_r + 1'b1;
        end
        if (idx_r == SW'(MAX_JOBS - 1)) begin
          state_nxt = hrrn_pkg::ST_SERVE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      hrrn_pkg::ST_SERVE: begin
        tbl_ctl.tick   = 1'b1;
        tbl_ctl.served = served;
        tbl_ctl.finish = finish;
        if (start) begin
          cur_nxt = best_idx_r;
        end
        if (served) begin
          rem_nxt  = rem_dec;
          busy_nxt = !finish;
        end
        time_nxt = time_inc;
        res_nxt  = '0;
        res_nxt[hrrn_pkg::OUT_SLOT_LSB +: hrrn_pkg::SLOT_W] =
          served ? cur_ext[hrrn_pkg::SLOT_W-1:0] : '0;
        res_nxt[hrrn_pkg::OUT_IDLE_BIT] = !served;
        res_nxt[hrrn_pkg::OUT_FIN_BIT]  = finish;
        res_nxt[hrrn_pkg::OUT_ALL_BIT]  = (nd_after == '0);
        res_nxt[hrrn_pkg::OUT_TICK_LSB +: hrrn_pkg::VAL_W] = time_ext[hrrn_pkg::VAL_W-1:0];
        state_nxt = hrrn_pkg::ST_OUT;
      end
      hrrn_pkg::ST_OUT: begin
        // hand over to the output register once it is free
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = res_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = hrrn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hrrn_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hrrn_pkg::ST_IDLE;
      job_count_r  <= hrrn_pkg::CFG_W'(1);
      idx_r        <= '0;
      found_r      <= 1'b0;
      nd_r         <= '0;
      busy_r       <= 1'b0;
      cur_r        <= '0;
      rem_r        <= '0;
      time_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      found_r      <= found_nxt;
      nd_r         <= nd_nxt;
      busy_r       <= busy_nxt;
      cur_r        <= cur_nxt;
      rem_r        <= rem_nxt;
      time_r       <= time_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        job_count_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_wait_r <= best_wait_nxt;
    best_len_r  <= best_len_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == hrrn_pkg::ST_IDLE);
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

endmodule

/* hdl/hrrn_chk.sv */
module hrrn_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hrrn_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an idle tick names slot zero and finishes nothing
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[hrrn_pkg::OUT_IDLE_BIT] |->
      (out_tdata[hrrn_pkg::OUT_SLOT_LSB +: hrrn_pkg::SLOT_W] == '0) &&
      !out_tdata[hrrn_pkg::OUT_FIN_BIT])
    else $error("idle result carries a slot or finish");

  // a tick occupies the block for its scan
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == hrrn_pkg::KIND_TICK) |=> !in_tready)
    else $error("ready right after a tick item");

  // the tick count field keeps its padding bit clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[hrrn_pkg::OUT_TDATA_W-1])
    else $error("result padding bit set");

endmodule

bind hrrn_job_scheduler_core hrrn_chk u_hrrn_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
